// ----- hdl/scmc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scmc_pkg
// shared constants and opcodes of the stack cpu math coprocessor
// ----------------------------------------------------------------------------
package scmc_pkg;
    localparam int DEF_CELL_WIDTH = 32;
    localparam int SEL_W = 11;
    localparam int OUT_W = 32;

    localparam logic [3:0] OP_MUL = 4'd9;
    localparam logic [3:0] OP_DIV = 4'd10;
    localparam logic [3:0] OP_SHF = 4'd11;
    localparam logic [3:0] OP_COL = 4'd12;

    localparam logic [3:0] RD_STATUS = 4'd1;
    localparam logic [3:0] RD_PHI    = 4'd2;
    localparam logic [3:0] RD_PLO    = 4'd3;
    localparam logic [3:0] RD_QUO    = 4'd4;
    localparam logic [3:0] RD_REM    = 4'd5;
    localparam logic [3:0] RD_SHI    = 4'd6;
    localparam logic [3:0] RD_SLO    = 4'd7;
    localparam logic [3:0] RD_COL    = 4'd8;

    localparam logic [1:0] COL_LOAD  = 2'd0;
    localparam logic [1:0] COL_MONO  = 2'd1;
    localparam logic [1:0] COL_PICK  = 2'd2;
    localparam logic [1:0] COL_BLEND = 2'd3;

    localparam logic [8:0] STATUS_READY = 9'h00F;
    localparam logic [8:0] STATUS_OVF   = 9'h100;
endpackage
`default_nettype wire

// ----- hdl/stack_cpu_math_coprocessor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stack_cpu_math_coprocessor
// shift-add multiply, restoring divide, double-cell shift and colour unit
// ----------------------------------------------------------------------------
// One beat in, at most one beat out. A trigger beat (kind 0) starts an
// operation and gives no result; a read beat (kind 1) returns the part of the
// last result chosen by the last select. Multiply runs 1 to 32 steps through
// a single cell-wide adder; divide runs CELL_WIDTH steps of one restoring
// compare-subtract each; a shift by n moves the double cell one bit per
// cycle; a rotate first reduces its count modulo CELL_WIDTH one bit per
// cycle and then turns the cell one bit per step; a gray blend works
// through its three colour planes in turn; other triggers finish at once.
// A read is answered in the cycle after it is taken, through the output
// register. Input is not taken while an operation runs or a read result
// waits.
module stack_cpu_math_coprocessor #(
    parameter int CELL_WIDTH = scmc_pkg::DEF_CELL_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: select[10:0], top_cell[42:11], next_cell[74:43], w_cell[106:75]
    input  wire logic [111:0] s_tdata,
    // tuser: kind
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: read_data[31:0]
    output logic [31:0]      m_tdata
);
    import scmc_pkg::*;

    localparam int CW = CELL_WIDTH;
    localparam int DW = 2 * CW;
    localparam int CNTW = $clog2(DW + 1);

    // shifter modes
    localparam logic [1:0] SH_RIGHT = 2'd0;
    localparam logic [1:0] SH_LEFT  = 2'd1;
    localparam logic [1:0] SH_ARITH = 2'd2;
    localparam logic [1:0] SH_ROT   = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_SHF    = 6'b001000,
        ST_BLEND  = 6'b010000,
        ST_ROTMOD = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // input fields
    logic [SEL_W-1:0] in_sel;
    logic [CW-1:0]    in_tos, in_nos, in_w;
    logic             in_kind;
    logic             take;
    assign in_kind = s_tuser;
    assign in_sel  = s_tdata[10:0];
    assign in_tos  = s_tdata[11 +: CW];
    assign in_nos  = s_tdata[43 +: CW];
    assign in_w    = s_tdata[75 +: CW];

    logic [SEL_W-1:0] sel_reg, sel_next;
    logic [DW-1:0]    prod_reg, prod_next;
    logic [DW-1:0]    shf_reg, shf_next;
    logic [CW-1:0]    quo_reg, quo_next, rem_reg, rem_next;
    logic             ovf_reg, ovf_next;
    logic [CW-1:0]    fore_reg, fore_next, back_reg, back_next;
    logic [CW-1:0]    mono_reg, mono_next, pix_reg, pix_next;
    // working registers
    logic [CW-1:0]    mcand_reg, mcand_next, dvs_reg, dvs_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [CNTW-1:0]  rmod_reg, rmod_next;
    logic             signed_reg, signed_next;
    logic [1:0]       shmode_reg, shmode_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_data_reg, out_data_next;

    logic             blend_start, blend_done;
    logic [CW-1:0]    blend_res;

    scmc_blend #(.CW(CW)) u_blend (
        .aclk(aclk), .aresetn(aresetn), .start(blend_start),
        .gray(in_tos[3:0]), .fore(fore_reg), .back(back_reg),
        .done(blend_done), .result(blend_res)
    );

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign take = s_tvalid && s_tready;

    // multiply step
    logic [CW:0]   m_a, m_b, m_sum;
    logic [DW-1:0] mul_step;
    // divide step
    logic [CW:0]   d_try;
    logic          d_ge;
    logic [CW-1:0] d_rem;
    // rotate count reduction step
    logic [CNTW-1:0] r_try, r_new;
    // colour read
    logic [CW-1:0] colour_rd;
    logic [31:0]   read_val;
    logic          wide_count;

    always_comb begin
        m_a = {signed_reg & mcand_reg[CW-1], mcand_reg};
        m_b = {signed_reg & prod_reg[DW-1], prod_reg[DW-1:CW]};
        m_sum = m_a + m_b;
        if (prod_reg[0]) mul_step = {m_sum, prod_reg[CW-1:1]};
        else mul_step = {signed_reg & prod_reg[DW-1], prod_reg[DW-1:1]};
    end

    always_comb begin
        // restoring step: partial remainder rem:quo shifted left one bit
        d_try = {rem_reg, quo_reg[CW-1]} - {1'b0, dvs_reg};
        d_ge = !d_try[CW];
        d_rem = d_ge ? d_try[CW-1:0] : {rem_reg[CW-2:0], quo_reg[CW-1]};
    end

    always_comb begin
        // count modulo cell width, one count bit per cycle from the top
        r_try = {rmod_reg[CNTW-2:0], dvs_reg[CW-1]};
        r_new = (r_try >= CNTW'(CW)) ? r_try - CNTW'(CW) : r_try;
    end

    always_comb begin
        case (sel_reg[7:5])
            3'd0: colour_rd = (pix_reg >> 10) & CW'(8'hFC);
            3'd1: colour_rd = (pix_reg >> 4) & CW'(8'hFC);
            3'd2: colour_rd = (pix_reg << 2) & CW'(8'hFC);
            3'd3: colour_rd = pix_reg;
            3'd4: colour_rd = ((pix_reg >> 10) & CW'(8'hF8)) | ((pix_reg >> 9) & CW'(3'h7));
            3'd5: colour_rd = (pix_reg >> 1) & CW'(8'hFF);
            3'd6: colour_rd = (pix_reg >> 9) & CW'(9'h1FF);
            default: colour_rd = pix_reg & CW'(9'h1FF);
        endcase
        case (sel_reg[3:0])
            RD_STATUS: read_val = 32'({ovf_reg ? STATUS_OVF : 9'h0} | STATUS_READY);
            RD_PHI:    read_val = 32'(prod_reg[DW-1:CW]);
            RD_PLO:    read_val = 32'(prod_reg[CW-1:0]);
            RD_QUO:    read_val = 32'(quo_reg);
            RD_REM:    read_val = 32'(rem_reg);
            RD_SHI:    read_val = 32'(shf_reg[DW-1:CW]);
            RD_SLO:    read_val = 32'(shf_reg[CW-1:0]);
            RD_COL:    read_val = 32'(colour_rd);
            default:   read_val = '0;
        endcase
    end

    assign wide_count = (in_w >= CW'(DW)) || (DW > CW && in_w[CW-1:0] >= CW'(DW));

    always_comb begin
        state_next = state_reg;
        sel_next = sel_reg; prod_next = prod_reg; shf_next = shf_reg;
        quo_next = quo_reg; rem_next = rem_reg; ovf_next = ovf_reg;
        fore_next = fore_reg; back_next = back_reg; mono_next = mono_reg;
        pix_next = pix_reg; mcand_next = mcand_reg; dvs_next = dvs_reg;
        cnt_next = cnt_reg; signed_next = signed_reg; shmode_next = shmode_reg;
        rmod_next = rmod_reg;
        out_valid_next = out_valid_reg; out_data_next = out_data_reg;
        blend_start = 1'b0;
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (take && in_kind) begin
                    out_valid_next = 1'b1;
                    out_data_next = read_val;
                end else if (take) begin
                    sel_next = in_sel;
                    case (in_sel[4:1])
                        OP_MUL: begin
                            prod_next = {{CW{1'b0}}, in_tos};
                            mcand_next = in_nos;
                            signed_next = in_sel[10];
                            cnt_next = CNTW'(in_sel[9:5]) + CNTW'(1);
                            state_next = ST_MUL;
                        end
                        OP_DIV: begin
                            if (in_w == '0 || in_tos >= in_w) begin
                                quo_next = '1; rem_next = '1; ovf_next = 1'b1;
                            end else begin
                                rem_next = in_tos; quo_next = in_nos;
                                dvs_next = in_w; ovf_next = 1'b0;
                                cnt_next = CNTW'(CW);
                                state_next = ST_DIV;
                            end
                        end
                        OP_SHF: begin
                            if (in_sel[7]) begin
                                shmode_next = SH_ROT;
                                shf_next = {{CW{1'b0}}, in_nos};
                                dvs_next = in_w;
                                rmod_next = '0;
                                cnt_next = CNTW'(CW);
                                state_next = ST_ROTMOD;
                            end else begin
                                shmode_next = in_sel[5] ? SH_LEFT
                                            : (in_sel[6] ? SH_ARITH : SH_RIGHT);
                                shf_next = {in_tos, in_nos};
                                if (wide_count) begin
                                    shf_next = (!in_sel[5] && in_sel[6] && in_tos[CW-1])
                                               ? '1 : '0;
                                end else begin
                                    cnt_next = CNTW'(in_w);
                                    state_next = ST_SHF;
                                end
                            end
                        end
                        OP_COL: begin
                            case (in_sel[6:5])
                                COL_LOAD: begin fore_next = in_tos; back_next = in_nos; end
                                COL_MONO: mono_next = in_w;
                                COL_PICK: begin
                                    pix_next = mono_reg[0] ? fore_reg : back_reg;
                                    mono_next = mono_reg >> 1;
                                end
                                default: begin
                                    blend_start = 1'b1;
                                    state_next = ST_BLEND;
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                prod_next = mul_step;
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) state_next = ST_IDLE;
            end
            ST_DIV: begin
                rem_next = d_rem;
                quo_next = {quo_reg[CW-2:0], d_ge};
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) state_next = ST_IDLE;
            end
            ST_ROTMOD: begin
                rmod_next = r_new;
                dvs_next = dvs_reg << 1;
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    cnt_next = r_new;
                    state_next = ST_SHF;
                end
            end
            ST_SHF: begin
                if (cnt_reg == '0) state_next = ST_IDLE;
                else begin
                    cnt_next = cnt_reg - CNTW'(1);
                    case (shmode_reg)
                        SH_RIGHT: shf_next = {1'b0, shf_reg[DW-1:1]};
                        SH_LEFT:  shf_next = {shf_reg[DW-2:0], 1'b0};
                        SH_ARITH: shf_next = {shf_reg[DW-1], shf_reg[DW-1:1]};
                        default:  shf_next = {{CW{1'b0}}, shf_reg[0], shf_reg[CW-1:1]};
                    endcase
                end
            end
            ST_BLEND: begin
                if (blend_done) begin
                    pix_next = blend_res;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sel_reg <= '0; prod_reg <= '0; shf_reg <= '0; quo_reg <= '0;
            rem_reg <= '0; ovf_reg <= 1'b0; fore_reg <= '0; back_reg <= '0;
            mono_reg <= '0; pix_reg <= '0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            sel_reg <= sel_next; prod_reg <= prod_next; shf_reg <= shf_next;
            quo_reg <= quo_next; rem_reg <= rem_next; ovf_reg <= ovf_next;
            fore_reg <= fore_next; back_reg <= back_next;
            mono_reg <= mono_next; pix_reg <= pix_next;
        end
        mcand_reg <= mcand_next; dvs_reg <= dvs_next; cnt_reg <= cnt_next;
        rmod_reg <= rmod_next;
        signed_reg <= signed_next; shmode_reg <= shmode_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // a held result stays put until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    // no input is taken while an operation runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("ready while busy");
    // a multiply never runs with a zero step count
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |-> cnt_reg != '0)
        else $error("multiply count underflow");
endmodule
`default_nettype wire

// ----- hdl/scmc_blend.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scmc_blend
// serial gray blend: one 6-bit colour plane per cycle through one mixer
// ----------------------------------------------------------------------------
module scmc_blend #(
    parameter int CW = scmc_pkg::DEF_CELL_WIDTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [3:0]    gray,
    input  wire logic [CW-1:0] fore,
    input  wire logic [CW-1:0] back,
    output logic               done,
    output logic [CW-1:0]      result
);
    import scmc_pkg::*;

    logic [1:0]    plane_reg, plane_next;
    logic          busy_reg, busy_next;
    logic [5:0]    g6_reg, g6_next;
    logic [CW-1:0] f_reg, f_next, b_reg, b_next, acc_reg, acc_next;
    logic [11:0]   mix;
    logic [5:0]    part;
    logic [CW-1:0] part_sh;

    // planes sit at bits 0, 6, 12; CW >= 18 so every plane fits
    always_comb begin
        mix = 12'(f_reg[5:0] * g6_reg) + 12'(b_reg[5:0] * (g6_reg ^ 6'h3F));
        part = mix[11:6];
        part_sh = CW'(part) << (6 * plane_reg);
    end

    always_comb begin
        plane_next = plane_reg;
        busy_next = busy_reg;
        g6_next = g6_reg;
        f_next = f_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        done = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            plane_next = 2'd0;
            g6_next = {gray, gray[3:2]};
            f_next = fore;
            b_next = back;
            acc_next = '0;
        end else if (busy_reg) begin
            acc_next = acc_reg + part_sh;
            f_next = f_reg >> 6;
            b_next = b_reg >> 6;
            plane_next = plane_reg + 2'd1;
            if (plane_reg == 2'd2) begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end
    assign result = acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            plane_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            plane_reg <= plane_next;
        end
        g6_reg <= g6_next;
        f_reg <= f_next;
        b_reg <= b_next;
        acc_reg <= acc_next;
    end
endmodule
`default_nettype wire
